>>> hdl/tica_pkg.sv
// tica_pkg: opcodes, fault codes and transfer structs for the typed integer alu
// no dependencies

package tica_pkg;

   localparam int DefMaxBytes = 16;

   localparam logic [4:0] OP_ADD = 5'd0;
   localparam logic [4:0] OP_SUB = 5'd1;
   localparam logic [4:0] OP_MUL = 5'd2;
   localparam logic [4:0] OP_DIV = 5'd3;
   localparam logic [4:0] OP_MOD = 5'd4;
   localparam logic [4:0] OP_SHR = 5'd5;
   localparam logic [4:0] OP_SHL = 5'd6;
   localparam logic [4:0] OP_AND = 5'd7;
   localparam logic [4:0] OP_OR = 5'd8;
   localparam logic [4:0] OP_XOR = 5'd9;
   localparam logic [4:0] OP_LAND = 5'd10;
   localparam logic [4:0] OP_LOR = 5'd11;
   localparam logic [4:0] OP_LT = 5'd12;
   localparam logic [4:0] OP_LTE = 5'd13;
   localparam logic [4:0] OP_GT = 5'd14;
   localparam logic [4:0] OP_GTE = 5'd15;
   localparam logic [4:0] OP_EQ = 5'd16;
   localparam logic [4:0] OP_NEQ = 5'd17;
   localparam logic [4:0] OP_POW = 5'd18;
   localparam logic [4:0] OP_PLUS = 5'd19;
   localparam logic [4:0] OP_NEG = 5'd20;
   localparam logic [4:0] OP_BITNOT = 5'd21;
   localparam logic [4:0] OP_NOT = 5'd22;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_DIV0 = 2'd1;
   localparam logic [1:0] FAULT_SHIFT = 2'd2;

   typedef struct packed {
      logic [4:0]  op;
      logic [63:0] a_value;
      logic [4:0]  a_bytes;
      logic        a_signed;
      logic [63:0] b_value;
      logic [4:0]  b_bytes;
      logic        b_signed;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [4:0]  result_bytes;
      logic        result_signed;
      logic [1:0]  fault;
   } rsp_type;

endpackage

>>> hdl/typed_integer_constant_alu.sv
// typed_integer_constant_alu: 64-bit alu on tagged operands
// one shared 32x32 multiplier and one restoring divide step under a sequencer
// depends on tica_pkg
//
//   channel | ports                        | transfer
//   input   | req_start, req_busy, req_data | start high and busy low at an edge
//   result  | rsp_strobe, rsp_data         | one cycle, strobe high
//
// the 64-bit multiply is three 32x32 partial products through one multiplier;
// pow spends two multiplies per set exponent bit, one per clear bit.
// reset is synchronous and clears control only; the receiver cannot stall,
// busy stays high from transfer to result strobe.

module typed_integer_constant_alu #(
   parameter int MAX_BYTES = tica_pkg::DefMaxBytes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              req_busy,
   input  tica_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tica_pkg::rsp_type rsp_data
);

   localparam logic [4:0] MaxB = 5'(MAX_BYTES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EXEC = 4'd1;
   localparam logic [3:0] S_MUL = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_DIVFIX = 4'd4;
   localparam logic [3:0] S_PBIT = 4'd5;
   localparam logic [3:0] S_PACC = 4'd6;
   localparam logic [3:0] S_PSQR = 4'd7;
   localparam logic [3:0] S_PEND = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [4:0]  op_ff, op_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [4:0]  rb_ff, rb_in;
   logic        rs_ff, rs_in;
   logic [63:0] r_ff, r_in;
   logic [1:0]  fault_ff, fault_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [1:0]  mph_ff, mph_in;
   logic [63:0] mx_ff, mx_in, my_ff, my_in, mp_ff, mp_in;
   logic [3:0]  mret_ff, mret_in;
   logic        na_ff, na_in, nb_ff, nb_in;

   logic [4:0]  ab, bb;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic [64:0] rem_sh;
   logic [64:0] rem_sub;
   logic        sgn;
   logic        lt_ab, lt_ba;

   assign ab = (req_data.a_bytes > MaxB) ? MaxB : req_data.a_bytes;
   assign bb = (req_data.b_bytes > MaxB) ? MaxB : req_data.b_bytes;

   always_comb begin
      unique case (mph_ff)
         2'd0:    begin mul_x = mx_ff[31:0];  mul_y = my_ff[31:0];  end
         2'd1:    begin mul_x = mx_ff[63:32]; mul_y = my_ff[31:0];  end
         2'd2:    begin mul_x = mx_ff[31:0];  mul_y = my_ff[63:32]; end
         default: begin mul_x = mx_ff[63:32]; mul_y = my_ff[63:32]; end
      endcase
   end
   assign mul_p = mul_x * mul_y;

   assign rem_sh = {rem_ff, acc_ff[63]};
   assign rem_sub = rem_sh - {1'b0, b_ff};

   assign sgn = rs_ff;
   assign lt_ab = sgn ? ($signed(a_ff) < $signed(b_ff)) : (a_ff < b_ff);
   assign lt_ba = sgn ? ($signed(b_ff) < $signed(a_ff)) : (b_ff < a_ff);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      rb_in = rb_ff;
      rs_in = rs_ff;
      r_in = r_ff;
      fault_in = fault_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      mph_in = mph_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      mp_in = mp_ff;
      mret_in = mret_ff;
      na_in = na_ff;
      nb_in = nb_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               op_in = req_data.op;
               a_in = req_data.a_value;
               b_in = req_data.b_value;
               if (req_data.op >= tica_pkg::OP_PLUS && req_data.op <= tica_pkg::OP_NOT) begin
                  rb_in = ab;
                  rs_in = req_data.a_signed;
               end else begin
                  rb_in = (ab > bb) ? ab : bb;
                  rs_in = req_data.a_signed | req_data.b_signed;
               end
               fault_in = tica_pkg::FAULT_NONE;
               r_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            unique case (op_ff)
               tica_pkg::OP_ADD: r_in = a_ff + b_ff;
               tica_pkg::OP_SUB: r_in = a_ff - b_ff;
               tica_pkg::OP_MUL: begin
                  mx_in = a_ff;
                  my_in = b_ff;
                  mp_in = '0;
                  mph_in = 2'd0;
                  mret_in = S_DONE;
                  state_in = S_MUL;
               end
               tica_pkg::OP_DIV, tica_pkg::OP_MOD: begin
                  if (b_ff == '0) begin
                     fault_in = tica_pkg::FAULT_DIV0;
                  end else begin
                     na_in = sgn & a_ff[63];
                     nb_in = sgn & b_ff[63];
                     acc_in = (sgn & a_ff[63]) ? -a_ff : a_ff;
                     b_in = (sgn & b_ff[63]) ? -b_ff : b_ff;
                     rem_in = '0;
                     cnt_in = '0;
                     state_in = S_DIV;
                  end
               end
               tica_pkg::OP_SHR, tica_pkg::OP_SHL: begin
                  if (b_ff[63:6] != '0) fault_in = tica_pkg::FAULT_SHIFT;
                  else if (op_ff == tica_pkg::OP_SHL) r_in = a_ff << b_ff[5:0];
                  else if (sgn) r_in = 64'($signed(a_ff) >>> b_ff[5:0]);
                  else r_in = a_ff >> b_ff[5:0];
               end
               tica_pkg::OP_AND: r_in = a_ff & b_ff;
               tica_pkg::OP_OR: r_in = a_ff | b_ff;
               tica_pkg::OP_XOR: r_in = a_ff ^ b_ff;
               tica_pkg::OP_LAND: r_in = 64'((a_ff != '0) && (b_ff != '0));
               tica_pkg::OP_LOR: r_in = 64'((a_ff != '0) || (b_ff != '0));
               tica_pkg::OP_LT: r_in = 64'(lt_ab);
               tica_pkg::OP_LTE: r_in = 64'(!lt_ba);
               tica_pkg::OP_GT: r_in = 64'(lt_ba);
               tica_pkg::OP_GTE: r_in = 64'(!lt_ab);
               tica_pkg::OP_EQ: r_in = 64'(a_ff == b_ff);
               tica_pkg::OP_NEQ: r_in = 64'(a_ff != b_ff);
               tica_pkg::OP_POW: begin
                  nb_in = sgn & b_ff[63];
                  if (sgn & b_ff[63]) b_in = -b_ff;
                  acc_in = 64'd1;
                  cnt_in = '0;
                  state_in = S_PBIT;
               end
               tica_pkg::OP_PLUS: r_in = a_ff;
               tica_pkg::OP_NEG: r_in = -a_ff;
               tica_pkg::OP_BITNOT: r_in = ~a_ff;
               tica_pkg::OP_NOT: r_in = 64'(a_ff == '0);
               default: r_in = '0;
            endcase
         end
         S_MUL: begin
            // low 64 bits of the product from three partial products
            unique case (mph_ff)
               2'd0: mp_in = mp_ff + mul_p;
               2'd1: mp_in = mp_ff + {mul_p[31:0], 32'd0};
               default: mp_in = mp_ff + {mul_p[31:0], 32'd0};
            endcase
            if (mph_ff == 2'd2) begin
               mph_in = 2'd0;
               state_in = mret_ff;
               if (mret_ff == S_DONE) r_in = mp_ff + {mul_p[31:0], 32'd0};
            end else begin
               mph_in = mph_ff + 2'd1;
            end
         end
         S_DIV: begin
            if (!rem_sub[64]) rem_in = rem_sub[63:0];
            else rem_in = rem_sh[63:0];
            acc_in = {acc_ff[62:0], ~rem_sub[64]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = S_DIVFIX;
         end
         S_DIVFIX: begin
            if (op_ff == tica_pkg::OP_DIV) r_in = (na_ff ^ nb_ff) ? -acc_ff : acc_ff;
            else r_in = na_ff ? -rem_ff : rem_ff;
            state_in = S_DONE;
         end
         S_PBIT: begin
            if (b_ff == '0) begin
               state_in = S_PEND;
            end else if (b_ff[0]) begin
               mx_in = acc_ff;
               my_in = a_ff;
               mp_in = '0;
               mret_in = S_PACC;
               state_in = S_MUL;
            end else begin
               mx_in = a_ff;
               my_in = a_ff;
               mp_in = '0;
               mret_in = S_PSQR;
               state_in = S_MUL;
            end
         end
         S_PACC: begin
            acc_in = mp_ff;
            mx_in = a_ff;
            my_in = a_ff;
            mp_in = '0;
            mret_in = S_PSQR;
            state_in = S_MUL;
         end
         S_PSQR: begin
            a_in = mp_ff;
            b_in = {1'b0, b_ff[63:1]};
            state_in = S_PBIT;
         end
         S_PEND: begin
            if (!nb_ff) r_in = acc_ff;
            else if (acc_ff == '0) fault_in = tica_pkg::FAULT_DIV0;
            else if (acc_ff == 64'd1) r_in = 64'd1;
            else if (acc_ff == '1) r_in = '1;
            else r_in = '0;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mph_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         mph_ff <= mph_in;
      end
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      rb_ff <= rb_in;
      rs_ff <= rs_in;
      r_ff <= r_in;
      fault_ff <= fault_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      mp_ff <= mp_in;
      mret_ff <= mret_in;
      na_ff <= na_in;
      nb_ff <= nb_in;
   end

   assign req_busy = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign rsp_data.result_value = r_ff;
   assign rsp_data.result_bytes = rb_ff;
   assign rsp_data.result_signed = rs_ff;
   assign rsp_data.fault = fault_ff;

endmodule
